// ----- rtl/tfh_pkg.sv -----
package tfh_pkg;

  localparam int TEMP_W   = 15;
  localparam int TARGET_W = 14;
  localparam int CODE_W   = 4;
  localparam int HOLD_W   = 3;
  localparam int CMP_W    = 17;

  localparam int SCALE_W   = 15;
  localparam int SCALE_NUM = 22900;

  localparam logic [TARGET_W-1:0] TARGET_RESET = TARGET_W'(1900);

  localparam logic signed [CMP_W-1:0] SPIKE_LIMIT = CMP_W'(150);
  localparam logic signed [CMP_W-1:0] NEAR_BAND   = CMP_W'(200);
  localparam logic signed [CMP_W-1:0] FAR_BAND    = CMP_W'(400);
  localparam logic signed [CMP_W-1:0] REARM_BAND  = CMP_W'(150);

  localparam logic [CODE_W-1:0] CODE_FULL = CODE_W'(0);
  localparam logic [CODE_W-1:0] CODE_OFF  = CODE_W'(11);
  localparam logic [CODE_W-1:0] HEAT_MID  = CODE_W'(5);
  localparam logic [CODE_W-1:0] HEAT_HIGH = CODE_W'(2);
  localparam logic [CODE_W-1:0] FAN_MID   = CODE_W'(6);
  localparam logic [CODE_W-1:0] FAN_HIGH  = CODE_W'(3);

  localparam logic [HOLD_W-1:0] HOLD_IDLE  = HOLD_W'(0);
  localparam logic [HOLD_W-1:0] HOLD_FIRST = HOLD_W'(1);
  localparam logic [HOLD_W-1:0] HOLD_LAST  = HOLD_W'(5);

endpackage

// ----- rtl/tfh_in_if.sv -----
interface tfh_in_if #(
  parameter int ADC_BITS = 12
);
  logic                valid;
  logic                ready;
  logic                sample_valid;
  logic [ADC_BITS-1:0] adc_code;
  logic                fan_force;

  modport source (output valid, sample_valid, adc_code, fan_force, input ready);
  modport sink   (input valid, sample_valid, adc_code, fan_force, output ready);
endinterface

// ----- rtl/tfh_out_if.sv -----
interface tfh_out_if
  import tfh_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [TEMP_W-1:0] temperature_centi;
  logic [CODE_W-1:0] heater_pwm_code;
  logic [CODE_W-1:0] fan_pwm_code;
  logic              heater_on;
  logic              reading_held;

  modport source (output valid, temperature_centi, heater_pwm_code, fan_pwm_code,
                  heater_on, reading_held, input ready);
  modport sink   (input valid, temperature_centi, heater_pwm_code, fan_pwm_code,
                  heater_on, reading_held, output ready);
endinterface

// ----- rtl/thermostat_fan_heater_control.sv -----
// Channel   | Dir | Handshake     | Payload
// in_ch     | in  | valid / ready | sample_valid, adc_code, fan_force
// out_ch    | out | valid / ready | temperature_centi, heater/fan pwm codes, heater_on,
//           |     |               | reading_held
// cfg_*     | in  | cfg_we only   | cfg_data = target temperature, hundredths of a degree
//
// One request per cycle while the result side takes results; a request passes the input register,
// then the state and result registers. The path between them is one reciprocal multiply (divide by
// AVG_SAMPLES) followed by the hold and band compares.
// Synchronous active-low reset; no clearing pass. A stalled result holds the state,
// and one further request waits in the input register.
module thermostat_fan_heater_control
  import tfh_pkg::*;
#(
  parameter int ADC_BITS    = 12,
  parameter int AVG_SAMPLES = 3
) (
  input  logic                clk,
  input  logic                rst_n,
  tfh_in_if.sink              in_ch,
  tfh_out_if.source           out_ch,
  input  logic                cfg_we,
  input  logic [TARGET_W-1:0] cfg_data
);

  localparam int CNT_W   = $clog2(AVG_SAMPLES + 1);
  localparam int PROD_W  = ADC_BITS + SCALE_W;
  localparam int ACC_W   = PROD_W + CNT_W;
  localparam int X_W     = ACC_W - ADC_BITS;
  localparam int SHIFT   = X_W + $clog2(AVG_SAMPLES);
  localparam int RECIP_W = SHIFT + 1;
  localparam int QP_W    = X_W + RECIP_W;
  localparam longint unsigned RECIP_L =
    ((64'd1 << SHIFT) + AVG_SAMPLES - 1) / AVG_SAMPLES;
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_L);
  localparam logic [CNT_W-1:0]   AVG_N = CNT_W'(AVG_SAMPLES);

  // input register
  logic                s1_valid_r;
  logic                s1_sample_r;
  logic [ADC_BITS-1:0] s1_code_r;
  logic                s1_force_r;

  // block state
  logic [TARGET_W-1:0] target_r;
  logic [ACC_W-1:0]    acc_r, acc_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [TEMP_W-1:0]   temp_r, temp_nxt;
  logic [TEMP_W-1:0]   last_r, last_nxt;
  logic                hold_r, hold_nxt;
  logic [HOLD_W-1:0]   steps_r, steps_nxt;
  logic                phase_r, phase_nxt;
  logic                rearm_r, rearm_nxt;
  logic [CODE_W-1:0]   heat_code_r, heat_code_nxt;
  logic [CODE_W-1:0]   fan_code_r, fan_code_nxt;
  logic                heater_r, heater_nxt;
  logic                out_valid_r;

  logic                 take;
  logic                 avg_now;
  logic [PROD_W-1:0]    prod;
  logic [QP_W-1:0]      qprod;
  logic [TEMP_W-1:0]    temp_avg;
  logic signed [CMP_W-1:0] diff, t_s, tg_s;

  assign take        = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || take;

  // accumulate sum * SCALE_NUM so the average needs only a shift and a divide by the sample count
  assign prod    = PROD_W'(s1_code_r) * PROD_W'(SCALE_NUM);
  assign avg_now = s1_sample_r && (count_r >= AVG_N);
  assign qprod   = QP_W'(acc_r[ACC_W-1:ADC_BITS]) * QP_W'(RECIP);
  assign temp_avg = qprod[SHIFT +: TEMP_W];

  always_comb begin
    acc_nxt   = acc_r;
    count_nxt = count_r;
    temp_nxt  = temp_r;
    last_nxt  = last_r;
    hold_nxt  = hold_r;
    steps_nxt = steps_r;
    diff      = '0;
    if (s1_sample_r) begin
      if (avg_now) begin
        temp_nxt  = temp_avg;
        acc_nxt   = '0;
        count_nxt = '0;
      end else begin
        acc_nxt   = acc_r + ACC_W'(prod);
        count_nxt = count_r + CNT_W'(1);
      end
      diff = CMP_W'({1'b0, temp_nxt}) - CMP_W'({1'b0, last_r});
      if (diff > SPIKE_LIMIT || diff < -SPIKE_LIMIT) begin
        hold_nxt = 1'b1;
      end
      if (hold_nxt && steps_nxt == HOLD_IDLE) begin
        temp_nxt  = last_r;
        steps_nxt = HOLD_FIRST;
      end
      if (hold_nxt && steps_nxt == HOLD_LAST) begin
        hold_nxt  = 1'b0;
        steps_nxt = HOLD_IDLE;
      end
      // the first hold tick also advances, so it leaves the counter at two
      if (steps_nxt >= HOLD_FIRST && steps_nxt < HOLD_LAST) begin
        steps_nxt = steps_nxt + HOLD_W'(1);
      end
      if (!hold_nxt) begin
        last_nxt = temp_nxt;
      end
    end
  end

  assign t_s  = CMP_W'({1'b0, temp_nxt});
  assign tg_s = CMP_W'({1'b0, target_r});

  always_comb begin
    heat_code_nxt = heat_code_r;
    fan_code_nxt  = fan_code_r;
    rearm_nxt     = rearm_r;
    phase_nxt     = phase_r;
    heater_nxt    = heater_r;

    if (t_s > tg_s - NEAR_BAND && t_s < tg_s + NEAR_BAND) begin
      if (phase_r) begin
        heat_code_nxt = HEAT_MID;
      end
    end else if (t_s > tg_s - FAR_BAND && t_s < tg_s - NEAR_BAND) begin
      heat_code_nxt = HEAT_HIGH;
    end else if (t_s < tg_s - FAR_BAND) begin
      heat_code_nxt = CODE_FULL;
    end else begin
      heat_code_nxt = CODE_OFF;
    end

    if (s1_force_r) begin
      fan_code_nxt = CODE_FULL;
    end else begin
      if (t_s > tg_s && t_s < tg_s + NEAR_BAND) begin
        if (!phase_r && rearm_r) begin
          fan_code_nxt = FAN_MID;
          rearm_nxt    = 1'b0;
        end
      end else if (t_s > tg_s + NEAR_BAND && t_s < tg_s + FAR_BAND) begin
        fan_code_nxt = FAN_HIGH;
      end else if (t_s >= tg_s + FAR_BAND) begin
        fan_code_nxt = CODE_FULL;
      end else begin
        fan_code_nxt = CODE_OFF;
      end
      if (t_s < tg_s - REARM_BAND) begin
        rearm_nxt = 1'b1;
      end
    end

    if (!phase_r && t_s < tg_s - NEAR_BAND) begin
      heater_nxt = 1'b1;
      phase_nxt  = 1'b1;
    end else if (phase_r && t_s > tg_s + NEAR_BAND) begin
      heater_nxt = 1'b0;
      phase_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      s1_sample_r <= in_ch.sample_valid;
      s1_code_r   <= in_ch.adc_code;
      s1_force_r  <= in_ch.fan_force;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      target_r    <= TARGET_RESET;
      acc_r       <= '0;
      count_r     <= '0;
      temp_r      <= '0;
      last_r      <= '0;
      hold_r      <= 1'b0;
      steps_r     <= HOLD_IDLE;
      phase_r     <= 1'b0;
      rearm_r     <= 1'b1;
      heat_code_r <= CODE_FULL;
      fan_code_r  <= CODE_FULL;
      heater_r    <= 1'b0;
    end else begin
      if (in_ch.ready) begin
        s1_valid_r <= in_ch.valid;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        target_r <= cfg_data;
      end
      if (take) begin
        acc_r       <= acc_nxt;
        count_r     <= count_nxt;
        temp_r      <= temp_nxt;
        last_r      <= last_nxt;
        hold_r      <= hold_nxt;
        steps_r     <= steps_nxt;
        phase_r     <= phase_nxt;
        rearm_r     <= rearm_nxt;
        heat_code_r <= heat_code_nxt;
        fan_code_r  <= fan_code_nxt;
        heater_r    <= heater_nxt;
      end
    end
  end

  // state only moves on a take, so the result reads straight from it
  assign out_ch.valid             = out_valid_r;
  assign out_ch.temperature_centi = temp_r;
  assign out_ch.heater_pwm_code   = heat_code_r;
  assign out_ch.fan_pwm_code      = fan_code_r;
  assign out_ch.heater_on         = heater_r;
  assign out_ch.reading_held      = hold_r;

`ifndef ASSERT_OFF
  a_hold_steps: assert property (@(posedge clk) disable iff (!rst_n)
    hold_r == (steps_r != HOLD_IDLE))
    else $error("hold flag and lock counter disagree");

  a_heater_phase: assert property (@(posedge clk) disable iff (!rst_n)
    heater_r == phase_r)
    else $error("heater level out of step with heating phase");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= AVG_N)
    else $error("sample count beyond average length");

  a_state_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(temp_r) && $stable(steps_r))
    else $error("state moved while result stalled");
`endif

endmodule

// ----- bench/tb_top.sv -----
module tb_top
  import tfh_pkg::*;
();

  localparam int ADC_BITS       = 12;
  localparam int AVG_SAMPLES    = 3;
  localparam int MAX_CODE       = (1 << ADC_BITS) - 1;
  localparam int AVG_DEN        = AVG_SAMPLES << ADC_BITS;
  localparam int SPIKE          = SPIKE_LIMIT;
  localparam int NEAR           = NEAR_BAND;
  localparam int FAR            = FAR_BAND;
  localparam int REARM          = REARM_BAND;
  localparam int TARGET_MAX     = (1 << TARGET_W) - 1;
  localparam int SETTLE_CODE    = 1000;
  localparam int SETTLED_CENTI  = 5590;  // three codes of 1000 through the scaling
  localparam int WALK_SPAN      = 110;
  localparam int WATCHDOG_LIMIT = 1000;

  typedef struct packed {
    logic [TEMP_W-1:0] temp;
    logic [CODE_W-1:0] heat_cmp;
    logic [CODE_W-1:0] fan_cmp;
    logic              heater_on;
    logic              held;
  } ctrl_result_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  logic [TARGET_W-1:0] cfg_data;

  tfh_in_if #(.ADC_BITS(ADC_BITS)) in_ch ();
  tfh_out_if out_ch ();

  thermostat_fan_heater_control #(
    .ADC_BITS   (ADC_BITS),
    .AVG_SAMPLES(AVG_SAMPLES)
  ) DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // thermostat state as the testbench sees it
  logic [TARGET_W-1:0] target_centi;
  logic [13:0]         avg_sum;
  logic [1:0]          avg_count;
  logic [TEMP_W-1:0]   cur_temp;
  logic [TEMP_W-1:0]   kept_temp;
  logic                hold_on;
  logic [HOLD_W-1:0]   hold_cnt;
  logic                heat_phase;
  logic                fan_armed;
  logic [CODE_W-1:0]   heat_cmp;
  logic [CODE_W-1:0]   fan_cmp;
  logic                heater_lvl;

  ctrl_result_t pending_ctrl[$];
  int           mismatches  = 0;
  int           tx_idle_pct = 0;
  int           rx_stall_pct = 0;
  int           rx_hold_left = 0;
  int           quiet_cycles = 0;

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    $display("%0t mismatch %s: got %0d want %0d", $realtime, what, got, want);
  endtask

  function automatic ctrl_result_t predict_tick(logic sv, logic [ADC_BITS-1:0] code, logic ff);
    int t;
    int tg;
    int diff;
    ctrl_result_t r;
    if (sv) begin
      if (avg_count >= 2'(AVG_SAMPLES)) begin
        // this sample is dropped, the sum so far becomes the new reading
        cur_temp  = TEMP_W'((int'(avg_sum) * SCALE_NUM) / AVG_DEN);
        avg_count = '0;
        avg_sum   = '0;
      end else begin
        avg_count = avg_count + 2'd1;
        avg_sum   = avg_sum + 14'(code);
      end
      diff = int'(cur_temp) - int'(kept_temp);
      if (diff > SPIKE || diff < -SPIKE) hold_on = 1'b1;
      if (hold_on && hold_cnt == HOLD_IDLE) begin
        cur_temp = kept_temp;
        hold_cnt = HOLD_FIRST;
      end
      if (hold_on && hold_cnt == HOLD_LAST) begin
        hold_on  = 1'b0;
        hold_cnt = HOLD_IDLE;
      end
      // the first step of a hold also advances here
      if (hold_cnt != HOLD_IDLE && hold_cnt < HOLD_LAST) hold_cnt = hold_cnt + HOLD_W'(1);
      if (!hold_on) kept_temp = cur_temp;
    end

    t  = int'(cur_temp);
    tg = int'(target_centi);

    if (t > tg - NEAR && t < tg + NEAR) begin
      if (heat_phase) heat_cmp = HEAT_MID;
    end else if (t > tg - FAR && t < tg - NEAR) begin
      heat_cmp = HEAT_HIGH;
    end else if (t < tg - FAR) begin
      heat_cmp = CODE_FULL;
    end else begin
      heat_cmp = CODE_OFF;
    end

    if (ff) begin
      fan_cmp = CODE_FULL;
    end else begin
      if (t > tg && t < tg + NEAR) begin
        if (!heat_phase && fan_armed) begin
          fan_cmp   = FAN_MID;
          fan_armed = 1'b0;
        end
      end else if (t > tg + NEAR && t < tg + FAR) begin
        fan_cmp = FAN_HIGH;
      end else if (t >= tg + FAR) begin
        fan_cmp = CODE_FULL;
      end else begin
        fan_cmp = CODE_OFF;
      end
      if (t < tg - REARM) fan_armed = 1'b1;
    end

    if (t < tg) begin
      if (!heat_phase && t < tg - NEAR) begin
        heater_lvl = 1'b1;
        heat_phase = 1'b1;
      end
    end else if (t > tg) begin
      if (heat_phase && t > tg + NEAR) begin
        heater_lvl = 1'b0;
        heat_phase = 1'b0;
      end
    end

    r.temp      = cur_temp;
    r.heat_cmp  = heat_cmp;
    r.fan_cmp   = fan_cmp;
    r.heater_on = heater_lvl;
    r.held      = hold_on;
    return r;
  endfunction

  // prediction on every accepted request and register write
  always @(posedge clk) begin
    if (!rst_n) begin
      target_centi = TARGET_RESET;
      avg_sum      = '0;
      avg_count    = '0;
      cur_temp     = '0;
      kept_temp    = '0;
      hold_on      = 1'b0;
      hold_cnt     = HOLD_IDLE;
      heat_phase   = 1'b0;
      fan_armed    = 1'b1;
      heat_cmp     = CODE_FULL;
      fan_cmp      = CODE_FULL;
      heater_lvl   = 1'b0;
    end else begin
      if (cfg_we) target_centi = cfg_data;
      if (in_ch.valid && in_ch.ready) begin
        pending_ctrl.push_back(predict_tick(in_ch.sample_valid, in_ch.adc_code,
                                            in_ch.fan_force));
      end
    end
  end

  always @(posedge clk) begin
    ctrl_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (pending_ctrl.size() == 0) begin
        report_mismatch("result with nothing pending, temp",
                        int'(out_ch.temperature_centi), 0);
      end else begin
        want = pending_ctrl.pop_front();
        if (out_ch.temperature_centi !== want.temp)
          report_mismatch("temperature_centi", int'(out_ch.temperature_centi),
                          int'(want.temp));
        if (out_ch.heater_pwm_code !== want.heat_cmp)
          report_mismatch("heater_pwm_code", int'(out_ch.heater_pwm_code),
                          int'(want.heat_cmp));
        if (out_ch.fan_pwm_code !== want.fan_cmp)
          report_mismatch("fan_pwm_code", int'(out_ch.fan_pwm_code), int'(want.fan_cmp));
        if (out_ch.heater_on !== want.heater_on)
          report_mismatch("heater_on", int'(out_ch.heater_on), int'(want.heater_on));
        if (out_ch.reading_held !== want.held)
          report_mismatch("reading_held", int'(out_ch.reading_held), int'(want.held));
      end
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // result side: random stalls, plus a long hold-off on request
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  task automatic send_tick(logic sv, logic [ADC_BITS-1:0] code, logic ff);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_ch.valid        <= 1'b1;
    in_ch.sample_valid <= sv;
    in_ch.adc_code     <= code;
    in_ch.fan_force    <= ff;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_ctrl.size() != 0) @(posedge clk);
  endtask

  task automatic write_target(logic [TARGET_W-1:0] value);
    cfg_data <= value;
    cfg_we   <= 1'b1;
    @(posedge clk);
    cfg_we   <= 1'b0;
  endtask

  // slow walk of the sensor code around the target, with spikes and stray codes
  task automatic send_random_ticks(int n, int tgt);
    int centre;
    int lo;
    int hi;
    int drift;
    int code;
    int pick;
    logic ff;
    centre = tgt * AVG_DEN / (AVG_SAMPLES * SCALE_NUM);
    lo     = (centre > WALK_SPAN) ? centre - WALK_SPAN : 0;
    hi     = (centre + WALK_SPAN < MAX_CODE) ? centre + WALK_SPAN : MAX_CODE;
    drift  = $urandom_range(hi, lo);
    repeat (n) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        code = $urandom_range(MAX_CODE);
      end else if (pick < 12) begin
        code = drift + ($urandom_range(1) ? 1 : -1) * int'($urandom_range(200, 60));
      end else begin
        drift = drift + int'($urandom_range(10)) - 5;
        if (drift < lo) drift = lo;
        if (drift > hi) drift = hi;
        code = drift + int'($urandom_range(4)) - 2;
      end
      if (code < 0) code = 0;
      if (code > MAX_CODE) code = MAX_CODE;
      ff = ($urandom_range(99) < 12);
      if ($urandom_range(99) < 70) send_tick(1'b1, ADC_BITS'(code), ff);
      else send_tick(1'b0, ADC_BITS'($urandom), ff);
    end
  endtask

  task automatic test_reset_target();
    send_tick(1'b0, ADC_BITS'(MAX_CODE), 1'b0);
    send_tick(1'b0, '0, 1'b1);
    send_tick(1'b0, '0, 1'b0);
  endtask

  // puts the temperature exactly on each band boundary by moving the target
  task automatic test_band_edges(int centre);
    int offs[5] = '{0, -NEAR, -FAR, NEAR, FAR};
    int tgt;
    foreach (offs[i]) begin
      tgt = centre + offs[i];
      if (tgt >= 0 && tgt <= TARGET_MAX) begin
        wait_drain();
        write_target(TARGET_W'(tgt));
        send_tick(1'b0, ADC_BITS'($urandom), logic'(i % 2));
      end
    end
  endtask

  task automatic test_spike_hold();
    repeat (8) send_tick(1'b1, ADC_BITS'(SETTLE_CODE), 1'b0);
  endtask

  task automatic test_adc_extremes();
    repeat (3) send_tick(1'b1, ADC_BITS'(MAX_CODE), 1'b0);
    repeat (3) send_tick(1'b1, '0, 1'b1);
  endtask

  task automatic test_random_traffic();
    int tgts[4];
    int tx_pcts[4] = '{0, 54, 0, 28};
    int rx_pcts[4] = '{0, 0, 54, 28};
    tgts = '{int'(TARGET_RESET), int'($urandom_range(12000)), 12000, 0};
    foreach (tgts[i]) begin
      wait_drain();
      write_target(TARGET_W'(tgts[i]));
      tx_idle_pct  = tx_pcts[i];
      rx_stall_pct = rx_pcts[i];
      send_random_ticks(190, tgts[i]);
    end
  endtask

  task automatic test_backpressure();
    wait_drain();
    write_target(TARGET_W'(TARGET_MAX));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    send_random_ticks(40, TARGET_MAX);
    // result side shuts for a while; requests keep coming until the input stalls
    rx_hold_left = 60;
    send_random_ticks(30, TARGET_MAX);
    wait_drain();
    tx_idle_pct  = 28;
    rx_stall_pct = 28;
    send_random_ticks(120, TARGET_MAX);
  endtask

  initial begin
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_data           <= '0;
    in_ch.valid        <= 1'b0;
    in_ch.sample_valid <= 1'b0;
    in_ch.adc_code     <= '0;
    in_ch.fan_force    <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_target();
    test_band_edges(0);
    test_spike_hold();
    test_band_edges(SETTLED_CENTI);
    test_adc_extremes();
    test_random_traffic();
    test_backpressure();

    wait_drain();
    repeat (4) @(posedge clk);
    if (pending_ctrl.size() != 0) report_mismatch("results never seen", 0, pending_ctrl.size());
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
